/* src/tpcp_pkg.sv */
// tpcp_pkg: fixed result field widths and the result word layout shared by
// the back end and the top level of the triangle plane closest point unit.
// No dependencies.
package tpcp_pkg;

  localparam int DET_W    = 52;
  localparam int WEIGHT_W = 53;
  localparam int NEAR_W   = 21;
  localparam int DIST_W   = 40;

  // One result transaction as stored in the output queue.
  localparam int OUT_W = 1 + DET_W + 2 * WEIGHT_W + 3 * NEAR_W + DIST_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage

/* src/tpcp_queue.sv */
// tpcp_queue: small first-word-fall-through queue built from flops.
// Overflow is prevented by the credit counters of the instantiating module.
// No dependencies.
module tpcp_queue #(
  parameter int WIDTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [1 << AW];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_pop;

  assign empty  = (count_r == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* src/tpcp_front.sv */
// tpcp_front: four-stage pipeline forming edge vectors, dot products, the
// Gram determinant and the two barycentric weights of each triangle.
// No dependencies.
module tpcp_front #(
  parameter int C = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go_i,
  input  logic signed [C-1:0]     p0_i  [3],
  input  logic signed [C-1:0]     p1_i  [3],
  input  logic signed [C-1:0]     p2_i  [3],
  output logic                    go_o,
  output logic signed [C-1:0]     p0_o  [3],
  output logic signed [C:0]       v1_o  [3],
  output logic signed [C:0]       v2_o  [3],
  output logic [4*C+3:0]          det_o,
  output logic signed [4*C+4:0]   l1_o,
  output logic signed [4*C+4:0]   l2_o
);

  localparam int VB  = C + 1;
  localparam int DB  = 2 * C + 3;
  localparam int PB  = 2 * DB;
  localparam int DTB = 4 * C + 4;
  localparam int LB  = 4 * C + 5;

  logic go1_r, go2_r, go3_r, go4_r;

  logic signed [C-1:0]  p0_1_r [3], p0_2_r [3], p0_3_r [3], p0_4_r [3];
  logic signed [VB-1:0] v1_1_r [3], v1_2_r [3], v1_3_r [3], v1_4_r [3];
  logic signed [VB-1:0] v2_1_r [3], v2_2_r [3], v2_3_r [3], v2_4_r [3];

  logic signed [DB-1:0] aa_r, ab_r, bb_r, pa_r, pb_r;
  logic signed [DB-1:0] aa_nxt, ab_nxt, bb_nxt, pa_nxt, pb_nxt;

  logic signed [PB-1:0] aabb_r, abab_r, pbab_r, pabb_r, paab_r, pbaa_r;
  logic [DTB-1:0]       det_r;
  logic signed [LB-1:0] l1_r, l2_r;

  logic signed [2*VB-1:0] m_aa [3], m_ab [3], m_bb [3], m_pa [3], m_pb [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go1_r <= 1'b0;
      go2_r <= 1'b0;
      go3_r <= 1'b0;
      go4_r <= 1'b0;
    end else begin
      go1_r <= go_i;
      go2_r <= go1_r;
      go3_r <= go2_r;
      go4_r <= go3_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_aa[k] = v1_1_r[k] * v1_1_r[k];
      m_ab[k] = v1_1_r[k] * v2_1_r[k];
      m_bb[k] = v2_1_r[k] * v2_1_r[k];
      m_pa[k] = p0_1_r[k] * v1_1_r[k];
      m_pb[k] = p0_1_r[k] * v2_1_r[k];
    end
    aa_nxt = DB'(m_aa[0]) + DB'(m_aa[1]) + DB'(m_aa[2]);
    ab_nxt = DB'(m_ab[0]) + DB'(m_ab[1]) + DB'(m_ab[2]);
    bb_nxt = DB'(m_bb[0]) + DB'(m_bb[1]) + DB'(m_bb[2]);
    pa_nxt = DB'(m_pa[0]) + DB'(m_pa[1]) + DB'(m_pa[2]);
    pb_nxt = DB'(m_pb[0]) + DB'(m_pb[1]) + DB'(m_pb[2]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p0_1_r[k] <= p0_i[k];
      v1_1_r[k] <= VB'(p1_i[k]) - VB'(p0_i[k]);
      v2_1_r[k] <= VB'(p2_i[k]) - VB'(p0_i[k]);
      p0_2_r[k] <= p0_1_r[k];
      v1_2_r[k] <= v1_1_r[k];
      v2_2_r[k] <= v2_1_r[k];
      p0_3_r[k] <= p0_2_r[k];
      v1_3_r[k] <= v1_2_r[k];
      v2_3_r[k] <= v2_2_r[k];
      p0_4_r[k] <= p0_3_r[k];
      v1_4_r[k] <= v1_3_r[k];
      v2_4_r[k] <= v2_3_r[k];
    end
    aa_r   <= aa_nxt;
    ab_r   <= ab_nxt;
    bb_r   <= bb_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    aabb_r <= aa_r * bb_r;
    abab_r <= ab_r * ab_r;
    pbab_r <= pb_r * ab_r;
    pabb_r <= pa_r * bb_r;
    paab_r <= pa_r * ab_r;
    pbaa_r <= pb_r * aa_r;
    det_r  <= DTB'(aabb_r - abab_r);
    l1_r   <= LB'(pbab_r - pabb_r);
    l2_r   <= LB'(paab_r - pbaa_r);
  end

  assign go_o  = go4_r;
  assign p0_o  = p0_4_r;
  assign v1_o  = v1_4_r;
  assign v2_o  = v2_4_r;
  assign det_o = det_r;
  assign l1_o  = l1_r;
  assign l2_o  = l2_r;

endmodule

/* src/tpcp_lane.sv */
// tpcp_lane: one coordinate of the nearest point: weighted numerator, a
// restoring divider pipelined one quotient bit per stage, offset and square.
// No dependencies.
module tpcp_lane #(
  parameter int C = 12,
  parameter int F = 8
) (
  input  logic                       clk,
  input  logic signed [4*C+4:0]      l1_i,
  input  logic signed [4*C+4:0]      l2_i,
  input  logic signed [C:0]          v1_i,
  input  logic signed [C:0]          v2_i,
  input  logic signed [C-1:0]        p0_i,
  input  logic [4*C+3:0]             den_i,
  output logic signed [C+F:0]        c_o,
  output logic [2*(C+F)-1:0]         csq_o
);

  localparam int VB  = C + 1;
  localparam int LB  = 4 * C + 5;
  localparam int DTB = 4 * C + 4;
  localparam int PRB = LB + VB;
  localparam int SMB = PRB + 1;
  localparam int NB  = SMB + F;
  localparam int QB  = C + F + 1;
  localparam int CB  = C + F + 1;
  localparam int MB  = C + F;

  logic signed [PRB-1:0] pr1_r, pr2_r;
  logic signed [C-1:0]   p0_1_r, p0_2_r, p0_3_r;
  logic [DTB-1:0]        den_1_r, den_2_r, den_3_r;
  logic signed [SMB-1:0] sum_r;
  logic [SMB-1:0]        abs_u;
  logic [NB-1:0]         mag_r;
  logic                  neg_r;

  logic [DTB-1:0]        rem_r [QB];
  logic [QB-1:0]         low_r [QB];
  logic [QB-1:0]         quo_r [QB];
  logic                  neg_d [QB];
  logic [DTB-1:0]        den_d [QB];
  logic signed [C-1:0]   p0_d  [QB];

  logic signed [CB:0]    q_s, c_w;
  logic signed [CB-1:0]  c_r, c2_r;
  logic [MB-1:0]         c_abs;
  logic [2*MB-1:0]       csq_r;

  assign abs_u = sum_r[SMB-1] ? SMB'(-sum_r) : SMB'(sum_r);

  always_ff @(posedge clk) begin
    pr1_r   <= l1_i * v1_i;
    pr2_r   <= l2_i * v2_i;
    p0_1_r  <= p0_i;
    den_1_r <= den_i;
    sum_r   <= SMB'(pr1_r) + SMB'(pr2_r);
    p0_2_r  <= p0_1_r;
    den_2_r <= den_1_r;
    mag_r   <= NB'(abs_u) << F;
    neg_r   <= sum_r[SMB-1];
    p0_3_r  <= p0_2_r;
    den_3_r <= den_2_r;
  end

  // The quotient magnitude is below 2^QB, so the bits above QB are already
  // smaller than the divisor and seed the partial remainder.
  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [DTB-1:0] rem_in;
    logic [QB-1:0]  low_in, quo_in;
    logic           neg_in;
    logic [DTB-1:0] den_in;
    logic signed [C-1:0] p0_in;
    logic [DTB:0]   trial, diff;
    logic           ge;

    if (s == 0) begin : g_first
      assign rem_in = DTB'(mag_r >> QB);
      assign low_in = mag_r[QB-1:0];
      assign quo_in = '0;
      assign neg_in = neg_r;
      assign den_in = den_3_r;
      assign p0_in  = p0_3_r;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign quo_in = quo_r[s-1];
      assign neg_in = neg_d[s-1];
      assign den_in = den_d[s-1];
      assign p0_in  = p0_d[s-1];
    end

    assign trial = {rem_in, low_in[QB-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? diff[DTB-1:0] : trial[DTB-1:0];
      low_r[s] <= low_in << 1;
      quo_r[s] <= {quo_in[QB-2:0], ge};
      neg_d[s] <= neg_in;
      den_d[s] <= den_in;
      p0_d[s]  <= p0_in;
    end
  end

  always_comb begin
    q_s = $signed({1'b0, quo_r[QB-1]});
    if (neg_d[QB-1]) begin
      q_s = -q_s;
    end
    c_w   = ((CB+1)'(p0_d[QB-1]) <<< F) + q_s;
    c_abs = c_r[CB-1] ? MB'(-c_r) : MB'(c_r);
  end

  always_ff @(posedge clk) begin
    c_r   <= c_w[CB-1:0];
    c2_r  <= c_r;
    csq_r <= c_abs * c_abs;
  end

  assign c_o   = c2_r;
  assign csq_o = csq_r;

endmodule

/* src/tpcp_back.sv */
// tpcp_back: three coordinate lanes plus the side pipeline carrying the
// determinant and weights, and the final distance sum with saturation.
// Depends on tpcp_pkg and tpcp_lane.
module tpcp_back import tpcp_pkg::*; #(
  parameter int C = 12,
  parameter int F = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go_i,
  input  logic signed [C-1:0]           p0_i [3],
  input  logic signed [C:0]             v1_i [3],
  input  logic signed [C:0]             v2_i [3],
  input  logic [4*C+3:0]                det_i,
  input  logic signed [4*C+4:0]         l1_i,
  input  logic signed [4*C+4:0]         l2_i,
  output logic                          wr_o,
  output logic                          valid_res_o,
  output logic [DET_W-1:0]              determinant_o,
  output logic signed [WEIGHT_W-1:0]    weight_second_o,
  output logic signed [WEIGHT_W-1:0]    weight_third_o,
  output logic signed [NEAR_W-1:0]      near_o [3],
  output logic [DIST_W-1:0]             distance_squared_o
);

  localparam int DTB = 4 * C + 4;
  localparam int LB  = 4 * C + 5;
  localparam int CB  = C + F + 1;
  localparam int MB  = C + F;
  localparam int LL  = C + F + 6;
  localparam int SW  = 2 * MB + 2;
  localparam int XW  = (SW > DIST_W) ? SW : DIST_W;

  logic signed [CB-1:0]  c_w   [3];
  logic [2*MB-1:0]       csq_w [3];

  logic                  go_d  [LL];
  logic [DTB-1:0]        det_d [LL];
  logic signed [LB-1:0]  l1_d  [LL];
  logic signed [LB-1:0]  l2_d  [LL];

  logic                  ok;
  logic [XW-1:0]         sum_x;

  logic                  wr_r;
  logic                  valid_r;
  logic [DET_W-1:0]      det_r;
  logic signed [WEIGHT_W-1:0] w2_r, w3_r;
  logic signed [NEAR_W-1:0]   near_r [3];
  logic [DIST_W-1:0]     dist_r;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tpcp_lane #(.C(C), .F(F)) u_lane (
      .clk   (clk),
      .l1_i  (l1_i),
      .l2_i  (l2_i),
      .v1_i  (v1_i[k]),
      .v2_i  (v2_i[k]),
      .p0_i  (p0_i[k]),
      .den_i (det_i),
      .c_o   (c_w[k]),
      .csq_o (csq_w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LL; i++) begin
        go_d[i] <= 1'b0;
      end
      wr_r <= 1'b0;
    end else begin
      go_d[0] <= go_i;
      for (int i = 1; i < LL; i++) begin
        go_d[i] <= go_d[i-1];
      end
      wr_r <= go_d[LL-1];
    end
  end

  always_ff @(posedge clk) begin
    det_d[0] <= det_i;
    l1_d[0]  <= l1_i;
    l2_d[0]  <= l2_i;
    for (int i = 1; i < LL; i++) begin
      det_d[i] <= det_d[i-1];
      l1_d[i]  <= l1_d[i-1];
      l2_d[i]  <= l2_d[i-1];
    end
  end

  assign ok    = (det_d[LL-1] != '0);
  assign sum_x = XW'(SW'(csq_w[0]) + SW'(csq_w[1]) + SW'(csq_w[2]));

  always_ff @(posedge clk) begin
    valid_r <= ok;
    det_r   <= DET_W'(det_d[LL-1]);
    w2_r    <= WEIGHT_W'(l1_d[LL-1]);
    w3_r    <= WEIGHT_W'(l2_d[LL-1]);
    for (int k = 0; k < 3; k++) begin
      near_r[k] <= ok ? NEAR_W'(c_w[k]) : '0;
    end
    if (!ok) begin
      dist_r <= '0;
    end else if (sum_x > XW'(DIST_MAX)) begin
      dist_r <= DIST_MAX;
    end else begin
      dist_r <= DIST_W'(sum_x);
    end
  end

  assign wr_o               = wr_r;
  assign valid_res_o        = valid_r;
  assign determinant_o      = det_r;
  assign weight_second_o    = w2_r;
  assign weight_third_o     = w3_r;
  assign near_o             = near_r;
  assign distance_squared_o = dist_r;

endmodule

/* src/triangle_plane_closest_point_unit.sv */
// Throughput: one triangle per cycle sustained while the receiver keeps popping
// results; the divider is pipelined one quotient bit per stage, so its depth sets
// most of the latency.
// Reset (synchronous, active low) empties both queues and clears the go bits of
// both pipelines and the credit counters; the datapath itself is not reset,
// nor is the valid_res flag.
//
// Top level of the triangle plane closest point unit. A four-stage front end
// computes edge vectors, dot products, the Gram determinant and the two
// barycentric weights. Its results wait in a small queue until the back end,
// which holds three divider lanes (one per coordinate), takes them. The back
// end writes finished results into the output queue. Each pipeline runs
// without stalls; credit counters admit a transaction only when a queue slot
// is certain to be free when it arrives, so either side can stall on its own.
// Depends on tpcp_pkg, tpcp_front, tpcp_queue, tpcp_back and tpcp_lane.
module triangle_plane_closest_point_unit import tpcp_pkg::*; #(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_first_z,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  input  logic signed [COORD_BITS-1:0] in_second_z,
  input  logic signed [COORD_BITS-1:0] in_third_x,
  input  logic signed [COORD_BITS-1:0] in_third_y,
  input  logic signed [COORD_BITS-1:0] in_third_z,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_valid_res,
  output logic [DET_W-1:0]             out_determinant,
  output logic signed [WEIGHT_W-1:0]   out_weight_second,
  output logic signed [WEIGHT_W-1:0]   out_weight_third,
  output logic signed [NEAR_W-1:0]     out_near_x,
  output logic signed [NEAR_W-1:0]     out_near_y,
  output logic signed [NEAR_W-1:0]     out_near_z,
  output logic [DIST_W-1:0]            out_distance_squared
);

  localparam int C   = COORD_BITS;
  localparam int VB  = C + 1;
  localparam int DTB = 4 * C + 4;
  localparam int LB  = 4 * C + 5;

  // Mid queue: must cover the four front stages plus the credit return to
  // keep one transaction per cycle flowing.
  localparam int MID_AW    = 3;
  localparam int MID_DEPTH = 1 << MID_AW;
  localparam int MID_W     = DTB + 2 * LB + 3 * C + 6 * VB;

  // Output queue: deep enough to hold everything in flight in the back end.
  localparam int BACK_LAT  = C + FRACTION_BITS + 7;
  localparam int OUT_AW    = $clog2(BACK_LAT + 2);
  localparam int OUT_DEPTH = 1 << OUT_AW;

  logic in_acc, mid_pop, out_acc;

  logic signed [C-1:0] p0_w [3], p1_w [3], p2_w [3];

  logic                 f_go;
  logic signed [C-1:0]  f_p0 [3];
  logic signed [VB-1:0] f_v1 [3], f_v2 [3];
  logic [DTB-1:0]       f_det;
  logic signed [LB-1:0] f_l1, f_l2;

  logic [MID_W-1:0]     mid_wdata, mid_rdata;
  logic                 mid_empty;

  logic signed [C-1:0]  b_p0 [3];
  logic signed [VB-1:0] b_v1 [3], b_v2 [3];
  logic [DTB-1:0]       b_det;
  logic signed [LB-1:0] b_l1, b_l2;

  logic                       b_wr;
  logic                       b_valid;
  logic [DET_W-1:0]           b_determinant;
  logic signed [WEIGHT_W-1:0] b_w2, b_w3;
  logic signed [NEAR_W-1:0]   b_near [3];
  logic [DIST_W-1:0]          b_dist;

  logic [OUT_W-1:0] out_wdata, out_rdata;

  // Credits: front_cnt counts transactions in the front end or the mid queue,
  // back_cnt those in the back end or the output queue.
  logic [MID_AW:0] front_cnt_r, front_cnt_nxt;
  logic [OUT_AW:0] back_cnt_r, back_cnt_nxt;

  assign in_full = (front_cnt_r == (MID_AW + 1)'(MID_DEPTH));
  assign in_acc  = in_push && !in_full;
  assign mid_pop = !mid_empty && (back_cnt_r != (OUT_AW + 1)'(OUT_DEPTH));
  assign out_acc = out_pop && !out_empty;

  always_comb begin
    case ({in_acc, mid_pop})
      2'b10:   front_cnt_nxt = front_cnt_r + 1'b1;
      2'b01:   front_cnt_nxt = front_cnt_r - 1'b1;
      default: front_cnt_nxt = front_cnt_r;
    endcase
    case ({mid_pop, out_acc})
      2'b10:   back_cnt_nxt = back_cnt_r + 1'b1;
      2'b01:   back_cnt_nxt = back_cnt_r - 1'b1;
      default: back_cnt_nxt = back_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_cnt_r <= '0;
      back_cnt_r  <= '0;
    end else begin
      front_cnt_r <= front_cnt_nxt;
      back_cnt_r  <= back_cnt_nxt;
    end
  end

  assign p0_w[0] = in_first_x;
  assign p0_w[1] = in_first_y;
  assign p0_w[2] = in_first_z;
  assign p1_w[0] = in_second_x;
  assign p1_w[1] = in_second_y;
  assign p1_w[2] = in_second_z;
  assign p2_w[0] = in_third_x;
  assign p2_w[1] = in_third_y;
  assign p2_w[2] = in_third_z;

  tpcp_front #(.C(C)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .go_i  (in_acc),
    .p0_i  (p0_w),
    .p1_i  (p1_w),
    .p2_i  (p2_w),
    .go_o  (f_go),
    .p0_o  (f_p0),
    .v1_o  (f_v1),
    .v2_o  (f_v2),
    .det_o (f_det),
    .l1_o  (f_l1),
    .l2_o  (f_l2)
  );

  assign mid_wdata = {f_det, f_l1, f_l2, f_p0[0], f_p0[1], f_p0[2],
                      f_v1[0], f_v1[1], f_v1[2], f_v2[0], f_v2[1], f_v2[2]};

  tpcp_queue #(.WIDTH(MID_W), .AW(MID_AW)) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_go),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign {b_det, b_l1, b_l2, b_p0[0], b_p0[1], b_p0[2],
          b_v1[0], b_v1[1], b_v1[2], b_v2[0], b_v2[1], b_v2[2]} = mid_rdata;

  tpcp_back #(.C(C), .F(FRACTION_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .go_i               (mid_pop),
    .p0_i               (b_p0),
    .v1_i               (b_v1),
    .v2_i               (b_v2),
    .det_i              (b_det),
    .l1_i               (b_l1),
    .l2_i               (b_l2),
    .wr_o               (b_wr),
    .valid_res_o        (b_valid),
    .determinant_o      (b_determinant),
    .weight_second_o    (b_w2),
    .weight_third_o     (b_w3),
    .near_o             (b_near),
    .distance_squared_o (b_dist)
  );

  assign out_wdata = {b_valid, b_determinant, b_w2, b_w3,
                      b_near[0], b_near[1], b_near[2], b_dist};

  tpcp_queue #(.WIDTH(OUT_W), .AW(OUT_AW)) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_wr),
    .wdata (out_wdata),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign {out_valid_res, out_determinant, out_weight_second, out_weight_third,
          out_near_x, out_near_y, out_near_z, out_distance_squared} = out_rdata;

endmodule

/* tb/triangle_plane_closest_point_checker.sv */
`timescale 1ns / 100ps
// Checker for the triangle plane closest point unit: it watches both queue ports,
// predicts each result from the accepted corners and compares the whole result word.
// Depends on tpcp_pkg for the result field widths.
module triangle_plane_closest_point_checker import tpcp_pkg::*; #(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic                         in_full,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_first_z,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  input  logic signed [COORD_BITS-1:0] in_second_z,
  input  logic signed [COORD_BITS-1:0] in_third_x,
  input  logic signed [COORD_BITS-1:0] in_third_y,
  input  logic signed [COORD_BITS-1:0] in_third_z,
  input  logic                         out_empty,
  input  logic                         out_pop,
  input  logic                         out_valid_res,
  input  logic [DET_W-1:0]             out_determinant,
  input  logic signed [WEIGHT_W-1:0]   out_weight_second,
  input  logic signed [WEIGHT_W-1:0]   out_weight_third,
  input  logic signed [NEAR_W-1:0]     out_near_x,
  input  logic signed [NEAR_W-1:0]     out_near_y,
  input  logic signed [NEAR_W-1:0]     out_near_z,
  input  logic [DIST_W-1:0]            out_distance_squared,
  output int                           failures,
  output int                           waiting
);

  typedef struct packed {
    logic                       valid_res;
    logic [DET_W-1:0]           determinant;
    logic signed [WEIGHT_W-1:0] weight_second;
    logic signed [WEIGHT_W-1:0] weight_third;
    logic signed [NEAR_W-1:0]   near_x;
    logic signed [NEAR_W-1:0]   near_y;
    logic signed [NEAR_W-1:0]   near_z;
    logic [DIST_W-1:0]          distance_squared;
  } plane_result_t;

  plane_result_t nearest_queue[$];
  int            mismatches = 0;

  assign failures = mismatches;
  assign waiting  = nearest_queue.size();

  function automatic plane_result_t nearest_point(longint p0[3], longint p1[3], longint p2[3]);
    longint                v1[3], v2[3];
    longint                aa, ab, bb, pa, pb, det, l1, l2, c;
    longint unsigned       mag, dist_sum;
    logic signed [127:0]   num, quo;
    plane_result_t         r;
    aa = 0; ab = 0; bb = 0; pa = 0; pb = 0; dist_sum = 0;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      v1[k] = p1[k] - p0[k];
      v2[k] = p2[k] - p0[k];
      aa += v1[k] * v1[k];
      ab += v1[k] * v2[k];
      bb += v2[k] * v2[k];
      pa += p0[k] * v1[k];
      pb += p0[k] * v2[k];
    end
    det = aa * bb - ab * ab;
    l1  = pb * ab - pa * bb;
    l2  = pa * ab - pb * aa;
    r.determinant   = det[DET_W-1:0];
    r.weight_second = l1[WEIGHT_W-1:0];
    r.weight_third  = l2[WEIGHT_W-1:0];
    if (det > 0) begin
      r.valid_res = 1'b1;
      for (int k = 0; k < 3; k++) begin
        // The numerator is kept at full width, so the quotient is exact and
        // truncated toward zero like the hardware divider.
        num = (128'(signed'(l1)) * 128'(signed'(v1[k])) +
               128'(signed'(l2)) * 128'(signed'(v2[k]))) <<< FRACTION_BITS;
        quo = num / 128'(signed'(det));
        c = p0[k] * (64'sd1 <<< FRACTION_BITS) + longint'(quo);
        case (k)
          0: r.near_x = c[NEAR_W-1:0];
          1: r.near_y = c[NEAR_W-1:0];
          default: r.near_z = c[NEAR_W-1:0];
        endcase
        mag = (c < 0) ? -c : c;
        if (mag > 64'h1FFFFF) mag = 64'h1FFFFF;
        dist_sum += mag * mag;
      end
      if (dist_sum > 64'(DIST_MAX)) dist_sum = 64'(DIST_MAX);
      r.distance_squared = dist_sum[DIST_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    longint        p0[3], p1[3], p2[3];
    plane_result_t got, want;
    if (rst_n && in_push && !in_full) begin
      p0 = '{longint'(in_first_x), longint'(in_first_y), longint'(in_first_z)};
      p1 = '{longint'(in_second_x), longint'(in_second_y), longint'(in_second_z)};
      p2 = '{longint'(in_third_x), longint'(in_third_y), longint'(in_third_z)};
      nearest_queue = {nearest_queue, nearest_point(p0, p1, p2)};
    end
    if (rst_n && out_pop && !out_empty) begin
      got = '{out_valid_res, out_determinant, out_weight_second, out_weight_third,
              out_near_x, out_near_y, out_near_z, out_distance_squared};
      if (nearest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = nearest_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result differs\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

endmodule

/* tb/triangle_plane_closest_point_unit_test.sv */
`timescale 1ns / 100ps
// Top of the testbench for the triangle plane closest point unit: it drives
// triangles and pops results, and gives the verdict from the checker's count.
// Depends on tpcp_pkg, the unit and triangle_plane_closest_point_checker.
module triangle_plane_closest_point_unit_test;
  import tpcp_pkg::*;

  localparam int CB         = 12;
  localparam int RANDOM_N   = 1800;
  localparam int CALM_TAIL  = 200;
  localparam int CYCLE_STOP = 600000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_push, in_full, out_empty, out_pop;
  logic signed [CB-1:0] in_first_x, in_first_y, in_first_z;
  logic signed [CB-1:0] in_second_x, in_second_y, in_second_z;
  logic signed [CB-1:0] in_third_x, in_third_y, in_third_z;
  logic                       out_valid_res;
  logic [DET_W-1:0]           out_determinant;
  logic signed [WEIGHT_W-1:0] out_weight_second, out_weight_third;
  logic signed [NEAR_W-1:0]   out_near_x, out_near_y, out_near_z;
  logic [DIST_W-1:0]          out_distance_squared;
  int   failures, waiting;
  int   cycles = 0;
  bit   calm = 1'b0;
  int   pop_hold = 0;

  always #5 clk = ~clk;

  triangle_plane_closest_point_unit dut (.*);
  triangle_plane_closest_point_checker chk (.*);

  // The run is cut off if the unit stops returning results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_STOP) begin
      $display("triangle_plane_closest_point_unit: mismatch");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except in the calm tail of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      out_pop  <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      pop_hold <= $urandom_range(1, 18) - 1;
      out_pop  <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Offers one triangle and holds it until the unit takes the transaction.
  // The push stays high afterwards; the caller lowers it only to idle.
  task automatic send_triangle(input logic [CB-1:0] c[9]);
    in_push     <= 1'b1;
    in_first_x  <= c[0]; in_first_y  <= c[1]; in_first_z  <= c[2];
    in_second_x <= c[3]; in_second_y <= c[4]; in_second_z <= c[5];
    in_third_x  <= c[6]; in_third_y  <= c[7]; in_third_z  <= c[8];
    do @(posedge clk); while (in_full);
  endtask

  task automatic sender_gap();
    in_push <= 1'b0;
    repeat ($urandom_range(1, 18)) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] any_coord();
    return CB'($urandom);
  endfunction

  // Random corners: mostly the full range, some clustered near the origin, and
  // some collinear or coincident so that the determinant comes out zero.
  function automatic void random_triangle(output logic [CB-1:0] c[9]);
    int kind, step;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      c[i] = any_coord();
      if (kind >= 6 && kind <= 7) c[i] = CB'($signed($urandom_range(0, 64)) - 32);
    end
    if (kind == 8) begin
      // Third corner on the line through the first two, kept inside range.
      step = $urandom_range(0, 3) - 1;
      for (int k = 0; k < 3; k++) begin
        c[k]     = CB'($signed($urandom_range(0, 1000)) - 500);
        c[3 + k] = CB'($signed($urandom_range(0, 1000)) - 500);
        c[6 + k] = CB'($signed(c[k]) + step * ($signed(c[3 + k]) - $signed(c[k])));
      end
    end else if (kind == 9) begin
      for (int k = 0; k < 3; k++) c[3 + k] = c[k];
    end
  endfunction

  initial begin
    logic [CB-1:0] tri_c[9];
    logic [CB-1:0] lo, hi;
    lo = {1'b1, {(CB-1){1'b0}}};
    hi = {1'b0, {(CB-1){1'b1}}};
    rst_n   <= 1'b0;
    in_push <= 1'b0;
    in_first_x  <= '0; in_first_y  <= '0; in_first_z  <= '0;
    in_second_x <= '0; in_second_y <= '0; in_second_z <= '0;
    in_third_x  <= '0; in_third_y  <= '0; in_third_z  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: all corners at the origin, extremes of every coordinate,
    // coincident and collinear corners, and simple well-formed triangles.
    tri_c = '{default: '0};                                  send_triangle(tri_c);
    tri_c = '{default: lo};                                  send_triangle(tri_c);
    tri_c = '{default: hi};                                  send_triangle(tri_c);
    tri_c = '{lo, lo, lo, hi, lo, lo, lo, hi, lo};           send_triangle(tri_c);
    tri_c = '{hi, hi, hi, lo, hi, hi, hi, lo, hi};           send_triangle(tri_c);
    tri_c = '{lo, lo, lo, hi, hi, hi, lo, hi, lo};           send_triangle(tri_c);
    tri_c = '{hi, lo, hi, lo, hi, lo, lo, lo, hi};           send_triangle(tri_c);
    tri_c = '{lo, hi, lo, hi, lo, lo, lo, lo, hi};           send_triangle(tri_c);
    tri_c = '{12'd1, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd0, 12'd1};
    send_triangle(tri_c);
    tri_c = '{12'd5, 12'd5, 12'd5, 12'd5, 12'd5, 12'd5, 12'd9, 12'd1, 12'd3};
    send_triangle(tri_c);
    tri_c = '{12'd1, 12'd2, 12'd3, 12'd2, 12'd4, 12'd6, 12'd3, 12'd6, 12'd9};
    send_triangle(tri_c);
    tri_c = '{12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd0, 12'd1, 12'd1, 12'd1};
    send_triangle(tri_c);
    tri_c = '{12'd100, 12'hF9C, 12'd7, 12'hC00, 12'd300, 12'd2047, 12'd9, 12'd0, 12'hFFF};
    send_triangle(tri_c);
    tri_c = '{hi, 12'd0, 12'd0, 12'd0, hi, 12'd0, 12'd0, 12'd0, hi};
    send_triangle(tri_c);
    tri_c = '{lo, 12'd0, 12'd0, 12'd0, lo, 12'd0, 12'd0, 12'd0, lo};
    send_triangle(tri_c);

    for (int n = 0; n < RANDOM_N; n++) begin
      if (n == RANDOM_N - CALM_TAIL) calm = 1'b1;
      if (n == RANDOM_N / 2) begin
        // Let the unit drain completely before going on.
        in_push <= 1'b0;
        do @(posedge clk); while (waiting != 0);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        sender_gap();
      end
      random_triangle(tri_c);
      send_triangle(tri_c);
    end
    in_push <= 1'b0;

    do @(posedge clk); while (waiting != 0);
    repeat (40) @(posedge clk);
    if (failures == 0 && waiting == 0) begin
      $display("triangle_plane_closest_point_unit: match");
    end else begin
      $display("triangle_plane_closest_point_unit: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
src/tpcp_pkg.sv
src/tpcp_queue.sv
src/tpcp_front.sv
src/tpcp_lane.sv
src/tpcp_back.sv
src/triangle_plane_closest_point_unit.sv
tb/triangle_plane_closest_point_checker.sv
tb/triangle_plane_closest_point_unit_test.sv
